[rtl/esv_pkg.sv]
`default_nettype none
package esv_pkg;

  localparam int MOD_WIDTH_DEF = 31;
  localparam int HASH_W        = 32;
  localparam int CFG_IDX_W     = 2;

  localparam int RST_P = 5;
  localparam int RST_G = 2;
  localparam int RST_X = 1;
  localparam int RST_Y = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_G = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y = 2'd3;

  localparam logic CMD_SIGN   = 1'b0;
  localparam logic CMD_VERIFY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONCE = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_M,
    S_AFT_M,
    S_DIV_K,
    S_EU_INIT,
    S_EU_TEST,
    S_EU_DIV,
    S_EU_MUL,
    S_EU_UPD,
    S_RED_G,
    S_SG_POW,
    S_SG_RM,
    S_SG_XM,
    S_SG_XR,
    S_SG_S,
    S_SG_FIN,
    S_RED_Y,
    S_VF_P1,
    S_VF_P2,
    S_VF_MUL,
    S_VF_G,
    S_VF_P3,
    S_VF_CMP,
    S_PW_SQ,
    S_PW_ML,
    S_PW_MLD,
    S_PW_NX,
    S_WAIT,
    S_DONE
  } esv_state_e;

endpackage
`default_nettype wire

[rtl/esv_mulmod.sv]
`default_nettype none
// Bit-serial modular multiply / divide: one multiplier bit per cycle, MSB first.
// acc = (a * b) mod m; with a = 1 the quotient bits of b / m collect in quo.
module esv_mulmod #(
  parameter int MW = esv_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [MW-1:0]              a_i,
  input  wire logic [esv_pkg::HASH_W-1:0] b_i,
  input  wire logic [MW-1:0]              m_i,
  output logic                            done_o,
  output logic [MW-1:0]                   res_o,
  output logic [esv_pkg::HASH_W-1:0]      quo_o
);
  import esv_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);

  logic [MW-1:0]     a_q, m_q, acc_q;
  logic [HASH_W-1:0] b_q, quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  logic [MW:0]   s1, s1r, s2, s2r;
  logic          sub1, sub2;

  always_comb begin
    s1   = {acc_q, 1'b0};
    sub1 = (s1 >= {1'b0, m_q});
    s1r  = sub1 ? (s1 - {1'b0, m_q}) : s1;
    s2   = s1r + (b_q[HASH_W-1] ? {1'b0, a_q} : '0);
    sub2 = (s2 >= {1'b0, m_q});
    s2r  = sub2 ? (s2 - {1'b0, m_q}) : s2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(HASH_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
      acc_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      acc_q <= s2r[MW-1:0];
      quo_q <= {quo_q[HASH_W-2:0], sub1 | sub2};
      b_q   <= {b_q[HASH_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

[rtl/elgamal_sign_verify.sv]
// ElGamal sign / verify over a configured prime, one transaction at a time.
// Every multiply and division runs on one shared bit-serial mod-multiply unit.
// Sign: Euclid rounds, 31 squarings and a multiply per set bit of k;
// verify: three exponentiations of 31 squarings each, plus a multiply per set exponent bit.
// A new command is taken only once the sequencer is back in idle; a result waits in the output register.
// Reset: p=5, g=2, x=1, y=2, sequencer idle, output empty; no memory clearing pass.
`default_nettype none
module elgamal_sign_verify #(
  parameter int MOD_WIDTH = esv_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [esv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [MOD_WIDTH-1:0]          cfg_data_i,
  // command transactions
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [esv_pkg::HASH_W-1:0]    message_hash_i,
  input  wire logic [MOD_WIDTH-1:0]          nonce_i,
  input  wire logic [MOD_WIDTH-1:0]          check_r_i,
  input  wire logic [MOD_WIDTH-1:0]          check_s_i,
  // result transactions
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [MOD_WIDTH-1:0]               sig_r_o,
  output logic [MOD_WIDTH-1:0]               sig_s_o,
  output logic [1:0]                         status_o
);
  import esv_pkg::*;

  localparam int MW   = MOD_WIDTH;
  localparam int PADW = HASH_W - MW;
  localparam int CW   = $clog2(MW);
  localparam logic [MW-1:0] ONE = MW'(1);

  // configuration registers
  logic [MW-1:0] p_q, g_q, x_q, y_q;

  // latched command
  logic              cmd_q;
  logic [HASH_W-1:0] hash_q;
  logic [MW-1:0]     k_q, cr_q, cs_q;

  // working registers
  esv_state_e    state_q, state_d, ret_q, pw_ret_q, op_ret;
  logic [MW-1:0] mh_q, ea_q, eb_q, t0_q, t1_q, rem_q;
  logic [MW-1:0] r_q, s_q, rm_q, v1_q;
  logic [MW-1:0] base_q, exp_q, acc_q;
  logic [CW-1:0] pw_cnt_q;
  logic [1:0]    status_q;

  // output register
  logic          out_valid_q;
  logic [MW-1:0] sig_r_q, sig_s_q;
  logic [1:0]    status_out_q;

  // shared unit
  logic              u_start, u_done;
  logic [MW-1:0]     u_a, u_m, u_res;
  logic [HASH_W-1:0] u_b, u_quo;

  logic [MW-1:0] pm1, diff, tn;
  logic          in_acc, out_free, vf_bad;

  assign pm1      = p_q - ONE;
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign vf_bad   = (cr_q == '0) || (cr_q >= p_q) || (cs_q >= pm1);
  // modular subtractions mod p-1; wraparound in MW bits lands in range
  assign diff     = (mh_q >= u_res) ? (mh_q - u_res) : (mh_q + pm1 - u_res);
  assign tn       = (t0_q >= u_res) ? (t0_q - u_res) : (t0_q + pm1 - u_res);

  esv_mulmod #(.MW(MW)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (u_start),
    .a_i     (u_a),
    .b_i     (u_b),
    .m_i     (u_m),
    .done_o  (u_done),
    .res_o   (u_res),
    .quo_o   (u_quo)
  );

  // unit operation issue (outputs of the sequencer)
  always_comb begin
    u_start = 1'b0;
    u_a     = ONE;
    u_b     = '0;
    u_m     = p_q;
    op_ret  = S_IDLE;
    unique case (state_q)
      S_DIV_M: begin
        u_start = 1'b1; u_b = hash_q; u_m = pm1; op_ret = S_AFT_M;
      end
      S_DIV_K: begin
        u_start = 1'b1; u_b = {{PADW{1'b0}}, k_q}; u_m = pm1; op_ret = S_EU_INIT;
      end
      S_EU_DIV: begin
        u_start = 1'b1; u_b = {{PADW{1'b0}}, ea_q}; u_m = eb_q; op_ret = S_EU_MUL;
      end
      S_EU_MUL: begin
        u_start = 1'b1; u_a = t1_q; u_b = u_quo; u_m = pm1; op_ret = S_EU_UPD;
      end
      S_RED_G: begin
        u_start = 1'b1; u_b = {{PADW{1'b0}}, g_q}; op_ret = S_SG_POW;
      end
      S_SG_RM: begin
        u_start = 1'b1; u_b = {{PADW{1'b0}}, acc_q}; u_m = pm1; op_ret = S_SG_XM;
      end
      S_SG_XM: begin
        u_start = 1'b1; u_b = {{PADW{1'b0}}, x_q}; u_m = pm1; op_ret = S_SG_XR;
      end
      S_SG_XR: begin
        u_start = 1'b1; u_a = u_res; u_b = {{PADW{1'b0}}, rm_q}; u_m = pm1;
        op_ret = S_SG_S;
      end
      S_SG_S: begin
        u_start = 1'b1; u_a = t0_q; u_b = {{PADW{1'b0}}, diff}; u_m = pm1;
        op_ret = S_SG_FIN;
      end
      S_RED_Y: begin
        u_start = 1'b1; u_b = {{PADW{1'b0}}, y_q}; op_ret = S_VF_P1;
      end
      S_VF_MUL: begin
        u_start = 1'b1; u_a = v1_q; u_b = {{PADW{1'b0}}, acc_q}; op_ret = S_VF_G;
      end
      S_VF_G: begin
        u_start = 1'b1; u_b = {{PADW{1'b0}}, g_q}; op_ret = S_VF_P3;
      end
      S_PW_SQ: begin
        u_start = 1'b1; u_a = acc_q; u_b = {{PADW{1'b0}}, acc_q}; op_ret = S_PW_ML;
      end
      S_PW_ML: begin
        // multiply in the base only for a set exponent bit
        u_start = exp_q[pw_cnt_q]; u_a = u_res; u_b = {{PADW{1'b0}}, base_q};
        op_ret = S_PW_MLD;
      end
      default: begin
        u_start = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (u_start) begin
      state_d = S_WAIT;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_d = (p_q < MW'(2)) ? S_DONE : S_DIV_M;
        end
        S_AFT_M: begin
          if (cmd_q == CMD_SIGN) state_d = S_DIV_K;
          else state_d = vf_bad ? S_DONE : S_RED_Y;
        end
        S_EU_INIT: state_d = S_EU_TEST;
        S_EU_TEST: begin
          if (eb_q != '0) state_d = S_EU_DIV;
          else state_d = (ea_q == ONE) ? S_RED_G : S_DONE;
        end
        S_EU_UPD: state_d = S_EU_TEST;
        S_SG_POW, S_VF_P1, S_VF_P2, S_VF_P3: state_d = S_PW_SQ;
        S_SG_FIN: state_d = S_DONE;
        S_VF_CMP: state_d = S_DONE;
        S_PW_ML:  state_d = S_PW_NX;
        S_PW_MLD: state_d = S_PW_NX;
        S_PW_NX:  state_d = (pw_cnt_q == '0) ? pw_ret_q : S_PW_SQ;
        S_WAIT:   if (u_done) state_d = ret_q;
        S_DONE:   if (out_free) state_d = S_IDLE;
        default:  state_d = state_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      pw_ret_q    <= S_IDLE;
      out_valid_q <= 1'b0;
      p_q         <= MW'(RST_P);
      g_q         <= MW'(RST_G);
      x_q         <= MW'(RST_X);
      y_q         <= MW'(RST_Y);
    end else begin
      state_q <= state_d;
      if (u_start) ret_q <= op_ret;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_P:   p_q <= cfg_data_i;
          CFG_G:   g_q <= cfg_data_i;
          CFG_X:   x_q <= cfg_data_i;
          CFG_Y:   y_q <= cfg_data_i;
          default: p_q <= p_q;
        endcase
      end
      unique case (state_q)
        S_SG_POW: pw_ret_q <= S_SG_RM;
        S_VF_P1:  pw_ret_q <= S_VF_P2;
        S_VF_P2:  pw_ret_q <= S_VF_MUL;
        S_VF_P3:  pw_ret_q <= S_VF_CMP;
        default:  pw_ret_q <= pw_ret_q;
      endcase
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q    <= cmd_i;
          hash_q   <= message_hash_i;
          k_q      <= nonce_i;
          cr_q     <= check_r_i;
          cs_q     <= check_s_i;
          status_q <= (cmd_i == CMD_SIGN) ? ST_NONCE : ST_FAIL;
        end
      end
      S_AFT_M: begin
        mh_q <= u_res;
      end
      S_EU_INIT: begin
        ea_q <= pm1;
        eb_q <= u_res;
        t0_q <= '0;
        t1_q <= (pm1 == ONE) ? '0 : ONE;
      end
      S_EU_MUL: rem_q <= u_res;
      S_EU_UPD: begin
        ea_q <= eb_q;
        eb_q <= rem_q;
        t0_q <= t1_q;
        t1_q <= tn;
      end
      S_SG_POW: begin
        base_q <= u_res; exp_q <= k_q; acc_q <= ONE; pw_cnt_q <= CW'(MW - 1);
      end
      S_SG_RM:  r_q  <= acc_q;
      S_SG_XM:  rm_q <= u_res;
      S_SG_FIN: begin
        s_q      <= u_res;
        status_q <= ST_OK;
      end
      S_VF_P1: begin
        base_q <= u_res; exp_q <= cr_q; acc_q <= ONE; pw_cnt_q <= CW'(MW - 1);
      end
      S_VF_P2: begin
        v1_q   <= acc_q;
        base_q <= cr_q; exp_q <= cs_q; acc_q <= ONE; pw_cnt_q <= CW'(MW - 1);
      end
      S_VF_G: v1_q <= u_res;
      S_VF_P3: begin
        base_q <= u_res; exp_q <= mh_q; acc_q <= ONE; pw_cnt_q <= CW'(MW - 1);
      end
      S_VF_CMP: status_q <= (acc_q == v1_q) ? ST_OK : ST_FAIL;
      S_PW_ML:  acc_q <= u_res;
      S_PW_MLD: acc_q <= u_res;
      S_PW_NX:  pw_cnt_q <= pw_cnt_q - 1'b1;
      S_DONE: begin
        if (out_free) begin
          status_out_q <= status_q;
          if (cmd_q == CMD_SIGN && status_q == ST_OK) begin
            sig_r_q <= r_q;
            sig_s_q <= s_q;
          end else begin
            sig_r_q <= '0;
            sig_s_q <= '0;
          end
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign sig_r_o     = sig_r_q;
  assign sig_s_o     = sig_s_q;
  assign status_o    = status_out_q;

endmodule
`default_nettype wire

[test/elgamal_sign_verify_tb.sv]
`default_nettype none
module elgamal_sign_verify_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esv_pkg::*;

  localparam int W = MOD_WIDTH_DEF;
  // Cycles with no transaction on either side before the run is declared hung.
  // The limit must exceed the long output hold below.
  localparam int HANG_LIMIT = 100000;
  localparam int LONG_HOLD  = 20000;
  localparam int TAIL_WAIT  = 8000;

  typedef struct packed {
    logic [W-1:0] r;
    logic [W-1:0] s;
    logic [1:0]   st;
  } sig_res_t;

  // Expected-signature store plus its own copy of p, g, x, y.
  class SigScoreboard;
    sig_res_t pending[$];
    longint unsigned p, g, x, y;
    int mismatches;

    function new();
      p = RST_P; g = RST_G; x = RST_X; y = RST_Y;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
      case (idx)
        CFG_P: p = val;
        CFG_G: g = val;
        CFG_X: x = val;
        default: y = val;
      endcase
    endfunction

    function longint unsigned exp_mod(longint unsigned b, longint unsigned e,
                                      longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      b = b % m;
      while (e != 0) begin
        if (e[0]) acc = (acc * b) % m;
        b = (b * b) % m;
        e = e >> 1;
      end
      return acc;
    endfunction

    // Extended Euclid; returns 0 when gcd(k, m) != 1
    function bit inverse(longint unsigned k, longint unsigned m,
                         output longint unsigned kinv);
      longint unsigned a, b, t0, t1, q, rem, tn;
      a = m; b = k % m; t0 = 0; t1 = 1 % m; kinv = 0;
      while (b != 0) begin
        q = a / b;
        rem = a - q * b;
        tn = (t0 + m - ((q % m) * t1) % m) % m;
        a = b; b = rem; t0 = t1; t1 = tn;
      end
      if (a != 1) return 0;
      kinv = t0;
      return 1;
    endfunction

    function sig_res_t predict(logic c, logic [31:0] h, logic [W-1:0] k,
                               logic [W-1:0] cr, logic [W-1:0] cs);
      sig_res_t res;
      longint unsigned pm1, m, kinv, r, xr, diff, v1, v2;
      res = '0;
      if (p < 2) begin
        res.st = (c == CMD_SIGN) ? ST_NONCE : ST_FAIL;
      end else begin
        pm1 = p - 1;
        m = h % pm1;
        if (c == CMD_SIGN) begin
          if (!inverse(k, pm1, kinv)) begin
            res.st = ST_NONCE;
          end else begin
            r = exp_mod(g, k, p);
            xr = ((x % pm1) * (r % pm1)) % pm1;
            diff = (m + pm1 - xr) % pm1;
            res.r = W'(r);
            res.s = W'((kinv * diff) % pm1);
            res.st = ST_OK;
          end
        end else if (cr == 0 || cr >= p || cs >= pm1) begin
          res.st = ST_FAIL;
        end else begin
          v1 = (exp_mod(y, cr, p) * exp_mod(cr, cs, p)) % p;
          v2 = exp_mod(g, m, p);
          res.st = (v1 == v2) ? ST_OK : ST_FAIL;
        end
      end
      return res;
    endfunction

    function void note_cmd(logic c, logic [31:0] h, logic [W-1:0] k,
                           logic [W-1:0] cr, logic [W-1:0] cs);
      pending.push_back(predict(c, h, k, cr, cs));
    endfunction

    function void check_result(logic [W-1:0] r, logic [W-1:0] s, logic [1:0] st);
      sig_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result r=%0d s=%0d status=%0d", r, s, st);
        return;
      end
      e = pending.pop_front();
      if (e.r !== r || e.s !== s || e.st !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp r=%0d s=%0d status=%0d, got r=%0d s=%0d status=%0d",
                   e.r, e.s, e.st, r, s, st);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, cmd_i;
  logic [HASH_W-1:0] message_hash_i;
  logic [W-1:0] nonce_i, check_r_i, check_s_i;
  logic out_valid_o, out_stall_i;
  logic [W-1:0] sig_r_o, sig_s_o;
  logic [1:0] status_o;

  elgamal_sign_verify #(.MOD_WIDTH(W)) dut (.*);

  SigScoreboard sb = new();

  // Phase controls for sender and receiver, plus the watchdog counter.
  bit no_idle   = 0;
  bit long_hold = 0;
  int hang_cnt  = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: compare every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(sig_r_o, sig_s_o, status_o);
  end

  // Watchdog on lack of progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      hang_cnt <= 0;
    end else begin
      hang_cnt <= hang_cnt + 1;
      if (hang_cnt >= HANG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: random hold-off before each result, one long hold on request.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 13);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // One command transaction; returns once it is accepted, after an optional random gap.
  task automatic send_cmd(logic c, logic [31:0] h, logic [W-1:0] k,
                          logic [W-1:0] cr, logic [W-1:0] cs);
    int gap;
    cmd_i <= c; message_hash_i <= h; nonce_i <= k;
    check_r_i <= cr; check_s_i <= cs;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_cmd(c, h, k, cr, cs);
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Registers only change with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
    in_valid_i <= 1'b0;
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic load_keys(longint unsigned p, longint unsigned g, longint unsigned x,
                           bit wrong_y);
    longint unsigned y;
    y = sb.exp_mod(g, x, p);
    if (wrong_y) y = (y % (p - 1)) + 1;
    write_reg(CFG_P, W'(p));
    write_reg(CFG_G, W'(g));
    write_reg(CFG_X, W'(x));
    write_reg(CFG_Y, W'(y));
  endtask

  // Random nonce: mostly in range of p-1, sometimes raw 31 bits.
  function automatic logic [W-1:0] pick_k(longint unsigned p);
    if ($urandom_range(0, 3) == 0) return W'($urandom);
    return W'($urandom_range(1, (p > 3) ? int'(p - 2) : 1));
  endfunction

  // Sign, then verify the predicted signature (sometimes tampered), plus noise.
  task automatic random_traffic(int count);
    sig_res_t sg;
    logic [31:0] h;
    logic [W-1:0] k, r, s;
    for (int i = 0; i < count; i++) begin
      h = $urandom;
      case ($urandom_range(0, 9))
        0, 1: begin
          send_cmd(CMD_VERIFY, $urandom, W'($urandom), W'($urandom), W'($urandom));
        end
        2: begin
          send_cmd(CMD_SIGN, h, W'($urandom), W'($urandom), W'($urandom));
        end
        default: begin
          k = pick_k(sb.p);
          sg = sb.predict(CMD_SIGN, h, k, '0, '0);
          send_cmd(CMD_SIGN, h, k, W'($urandom), W'($urandom));
          r = sg.r; s = sg.s;
          case ($urandom_range(0, 5))
            0: h = h ^ (32'h1 << $urandom_range(0, 31));
            1: s = s + 1'b1;
            2: r = r ^ (31'h1 << $urandom_range(0, 30));
            default: ;
          endcase
          send_cmd(CMD_VERIFY, h, W'($urandom), r, s);
          i++;
        end
      endcase
    end
  endtask

  initial begin
    sig_res_t sg;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; cmd_i = 1'b0; message_hash_i = '0;
    nonce_i = '0; check_r_i = '0; check_s_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset keys p=5 g=2 x=1 y=2.
    send_cmd(CMD_SIGN, 32'd7, 31'd1, '0, '0);
    send_cmd(CMD_SIGN, 32'd0, 31'd3, '0, '0);
    send_cmd(CMD_SIGN, 32'hFFFF_FFFF, 31'd2, '0, '0);     // k shares factor with p-1
    send_cmd(CMD_SIGN, 32'd5, 31'd0, '0, '0);             // k = 0
    send_cmd(CMD_SIGN, 32'd9, 31'h7FFF_FFFF, '0, '0);     // k beyond p-1
    sg = sb.predict(CMD_SIGN, 32'd3, 31'd3, '0, '0);
    send_cmd(CMD_VERIFY, 32'd3, '0, sg.r, sg.s);
    send_cmd(CMD_VERIFY, 32'd3, '0, 31'd0, 31'd1);        // r = 0
    send_cmd(CMD_VERIFY, 32'd3, '0, 31'd5, 31'd1);        // r >= p
    send_cmd(CMD_VERIFY, 32'd3, '0, 31'd2, 31'd4);        // s >= p-1
    send_cmd(CMD_VERIFY, 32'd3, '0, 31'd2, 31'd0);        // s = 0
    send_cmd(CMD_VERIFY, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);

    // Degenerate moduli: p = 2 works mod 1, p below 2 is rejected outright.
    write_reg(CFG_P, 31'd2);
    send_cmd(CMD_SIGN, 32'd9, 31'd3, '0, '0);
    send_cmd(CMD_VERIFY, 32'd9, '0, 31'd1, 31'd0);
    write_reg(CFG_P, 31'd1);
    send_cmd(CMD_SIGN, 32'd9, 31'd3, '0, '0);
    send_cmd(CMD_VERIFY, 32'd9, '0, 31'd1, 31'd0);
    write_reg(CFG_P, 31'd0);
    send_cmd(CMD_SIGN, 32'd9, 31'd1, '0, '0);
    send_cmd(CMD_VERIFY, 32'd9, '0, 31'd1, 31'd0);

    // Directed, largest field, register extremes (g and x out at their ceilings).
    load_keys(64'd2147483647, 64'd2147483646, 64'd2147483645, 0);
    send_cmd(CMD_SIGN, 32'hFFFF_FFFF, 31'd1, '0, '0);
    send_cmd(CMD_SIGN, 32'd0, 31'h7FFF_FFFD, '0, '0);
    send_cmd(CMD_SIGN, 32'h8000_0000, 31'h7FFF_FFFE, '0, '0); // k = p-1, not coprime
    sg = sb.predict(CMD_SIGN, 32'h1234_5678, 31'd11, '0, '0);
    send_cmd(CMD_VERIFY, 32'h1234_5678, '0, sg.r, sg.s);
    send_cmd(CMD_VERIFY, 32'd0, '0, 31'h7FFF_FFFE, 31'h7FFF_FFFD);
    send_cmd(CMD_VERIFY, 32'd1, '0, 31'h7FFF_FFFF, 31'd0);

    // Random phases over several fields; mostly sign/verify pairs.
    load_keys(64'd2147483647, 64'd7, $urandom_range(1, 2147483645), 0);
    random_traffic(70);
    load_keys(64'd11, 64'd2, 64'd7, 0);
    no_idle = 1;                  // back-to-back stretch
    random_traffic(50);
    no_idle = 0;
    load_keys(64'd7, 64'd3, 64'd5, 0);
    long_hold = 1;                // output held off; input backs up behind it
    random_traffic(50);
    load_keys(64'd65521, 64'd17, $urandom_range(1, 65519), 0);
    random_traffic(70);
    load_keys(64'd1000003, 64'd2, $urandom_range(1, 1000001), 1);  // y not matching x
    random_traffic(50);
    load_keys(64'd13, 64'd2, 64'd11, 0);
    random_traffic(50);
    load_keys(64'd5, 64'd2, 64'd1, 0);
    random_traffic(40);
    load_keys(64'd2147483647, 64'd16807, $urandom_range(1, 2147483645), 0);
    random_traffic(100);

    in_valid_i <= 1'b0;
    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
